@@ sv/rtc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and constants of the route table CAM
// Request kinds, result status codes, sequencer states and the structs that
// pass between the sequencer, the entry store and the top level.
// ----------------------------------------------------------------------------
package rtc_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int MAC_W    = 48;
    localparam int IP_W     = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT   = 3'd0,
        KIND_FIND_IP  = 3'd1,
        KIND_FIND_MAC = 3'd2,
        KIND_DEL_IP   = 3'd3,
        KIND_DEL_MAC  = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } seq_state_t;

    // write-side commands to the entry store
    typedef struct packed {
        logic set_en;   // write key pair, mark slot valid
        logic clr_en;   // mark slot free
    } store_op_t;

    typedef struct packed {
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } result_t;

endpackage

@@ sv/route_table_cam_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// route_table_cam_top: route table CAM
// Table of MAC / IPv4 route entries with insert, find and delete requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the request kind,
//   s_tdata the key pair. Each accepted item gives exactly one result item
//   on the m_ channel: m_tuser carries the status, m_tdata the slot and the
//   stored pair (all zero when the status is not ok).
//   The sequencer scans the slots one per cycle through the single
//   registered read port of the entry store and one shared comparator.
//   An item's slots are read in turn through the registered read port and
//   compared; the scan stops at the first slot that fits the request or
//   after the last slot, and the result passes from the sequencer's result
//   register into the output register. s_tready is high only while no item
//   is in the sequencer, so one item is handled at a time: the next item is
//   taken only once the sequencer has passed its result on.
//   A finished result waits in the output register; a new item is taken
//   while it waits, and the sequencer holds its own result until the
//   output register frees up. A stalled receiver therefore stops intake
//   only once a second result is ready.
//   Reset clears every valid flag at once: the table is empty from the
//   first cycle after reset and no clearing pass is needed.
// ----------------------------------------------------------------------------
module route_table_cam_top
    import rtc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,    // key_mac[47:0], key_ip[79:48]
    input  logic [7:0]  s_tuser,    // kind[2:0], zero above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,    // slot[3:0], found_mac[51:4], found_ip[83:52], zero above
    output logic [7:0]  m_tuser     // status[1:0], zero above
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                   res_valid;
    logic                   res_ready;
    result_t                res;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;
    logic [MAC_W-1:0]       rd_mac;
    logic [IP_W-1:0]        rd_ip;
    store_op_t              op;
    logic [AW-1:0]          wr_addr;
    logic [MAC_W-1:0]       wr_mac;
    logic [IP_W-1:0]        wr_ip;
    logic [TABLE_DEPTH-1:0] valid;

    logic                   m_valid_reg, m_valid_next;
    result_t                m_res_reg;

    rtc_seq #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser[KIND_W-1:0]),
        .in_mac    (s_tdata[MAC_W-1:0]),
        .in_ip     (s_tdata[MAC_W+IP_W-1:MAC_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_mac    (rd_mac),
        .rd_ip     (rd_ip),
        .op        (op),
        .wr_addr   (wr_addr),
        .wr_mac    (wr_mac),
        .wr_ip     (wr_ip),
        .valid     (valid)
    );

    rtc_store #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_mac  (rd_mac),
        .rd_ip   (rd_ip),
        .op      (op),
        .wr_addr (wr_addr),
        .wr_mac  (wr_mac),
        .wr_ip   (wr_ip),
        .valid   (valid)
    );

    // output register: take a result when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_res_reg.ip, m_res_reg.mac, m_res_reg.slot};
    assign m_tuser  = {6'd0, m_res_reg.status};

endmodule

@@ sv/rtc_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_store: route entry storage
// MAC and IP memories with one write and one registered read port, plus a
// vector of valid flags that reset clears.
// ----------------------------------------------------------------------------
module rtc_store
    import rtc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output logic [MAC_W-1:0]       rd_mac,
    output logic [IP_W-1:0]        rd_ip,
    input  store_op_t              op,
    input  logic [AW-1:0]          wr_addr,
    input  logic [MAC_W-1:0]       wr_mac,
    input  logic [IP_W-1:0]        wr_ip,
    output logic [TABLE_DEPTH-1:0] valid
);

    logic [MAC_W-1:0]       mac_mem [TABLE_DEPTH];
    logic [IP_W-1:0]        ip_mem  [TABLE_DEPTH];
    logic [MAC_W-1:0]       rd_mac_reg;
    logic [IP_W-1:0]        rd_ip_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;

    always_ff @(posedge aclk) begin
        if (op.set_en) begin
            mac_mem[wr_addr] <= wr_mac;
            ip_mem[wr_addr]  <= wr_ip;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_mac_reg <= mac_mem[rd_addr];
            rd_ip_reg  <= ip_mem[rd_addr];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (op.set_en) begin
            valid_next[wr_addr] = 1'b1;
        end else if (op.clr_en) begin
            valid_next[wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign rd_mac = rd_mac_reg;
    assign rd_ip  = rd_ip_reg;
    assign valid  = valid_reg;

endmodule

@@ sv/rtc_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_seq: scan sequencer and shared compare unit
// Walks the slots one per cycle through the store's read port, tests each
// with one comparator and builds the result for the item.
// ----------------------------------------------------------------------------
module rtc_seq
    import rtc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // request side
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [KIND_W-1:0]      in_kind,
    input  logic [MAC_W-1:0]       in_mac,
    input  logic [IP_W-1:0]        in_ip,
    // result side
    output logic                   res_valid,
    input  logic                   res_ready,
    output result_t                res,
    // store access
    output logic                   rd_en,
    output logic [AW-1:0]          rd_addr,
    input  logic [MAC_W-1:0]       rd_mac,
    input  logic [IP_W-1:0]        rd_ip,
    output store_op_t              op,
    output logic [AW-1:0]          wr_addr,
    output logic [MAC_W-1:0]       wr_mac,
    output logic [IP_W-1:0]        wr_ip,
    input  logic [TABLE_DEPTH-1:0] valid
);

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_C  = AW'(TABLE_DEPTH - 1);

    seq_state_t        state_reg, state_next;
    logic [KIND_W-1:0] kind_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [IP_W-1:0]   ip_reg;
    logic [CW-1:0]     issue_reg, issue_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]     cmp_idx_reg, cmp_idx_next;
    result_t           res_reg, res_next;

    logic              accept;
    logic              slot_ok;
    logic              hit;
    logic              last;
    logic              is_insert;
    logic              is_delete;

    assign accept    = in_valid && in_ready;
    assign is_insert = (kind_reg == KIND_INSERT);
    assign is_delete = (kind_reg == KIND_DEL_IP) || (kind_reg == KIND_DEL_MAC);

    // shared compare: one slot per cycle
    always_comb begin
        case (kind_reg)
            KIND_INSERT:                slot_ok = !valid[cmp_idx_reg];
            KIND_FIND_IP, KIND_DEL_IP:  slot_ok = valid[cmp_idx_reg] && (rd_ip == ip_reg);
            KIND_FIND_MAC, KIND_DEL_MAC: slot_ok = valid[cmp_idx_reg] && (rd_mac == mac_reg);
            default:                    slot_ok = 1'b0;
        endcase
    end

    assign hit  = cmp_vld_reg && slot_ok;
    assign last = cmp_vld_reg && (cmp_idx_reg == LAST_C);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (hit || last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready     = (state_reg == S_IDLE);
        res_valid    = (state_reg == S_DONE);
        rd_en        = 1'b0;
        rd_addr      = issue_reg[AW-1:0];
        issue_next   = issue_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        op.set_en    = 1'b0;
        op.clr_en    = 1'b0;
        res_next     = res_reg;
        case (state_reg)
            S_IDLE: begin
                issue_next = '0;
            end
            S_SCAN: begin
                if (issue_reg < DEPTH_C) begin
                    rd_en        = 1'b1;
                    issue_next   = issue_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[AW-1:0];
                end
                if (hit) begin
                    op.set_en       = is_insert;
                    op.clr_en       = is_delete;
                    res_next.status = ST_OK;
                    res_next.slot   = SLOT_W'(cmp_idx_reg);
                    res_next.mac    = is_insert ? mac_reg : rd_mac;
                    res_next.ip     = is_insert ? ip_reg : rd_ip;
                end else if (last) begin
                    res_next.status = is_insert ? ST_FULL : ST_MISS;
                    res_next.slot   = '0;
                    res_next.mac    = '0;
                    res_next.ip     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign wr_addr = cmp_idx_reg;
    assign wr_mac  = mac_reg;
    assign wr_ip   = ip_reg;
    assign res     = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cmp_vld_reg <= 1'b0;
            issue_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            issue_reg   <= issue_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= in_kind;
            mac_reg  <= in_mac;
            ip_reg   <= in_ip;
        end
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
    end

    a_op_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(op.set_en && op.clr_en))
        else $error("store set and clear in the same cycle");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (issue_reg <= DEPTH_C))
        else $error("scan counter ran past the table");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && (res_reg.status != ST_OK)) |->
            (res_reg.slot == '0 && res_reg.mac == '0 && res_reg.ip == '0))
        else $error("failed request carries a nonzero payload");

    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_reg)))
        else $error("pending result changed before handover");

    a_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (op.set_en || op.clr_en) |=> (state_reg == S_DONE))
        else $error("store updated without finishing the scan");

endmodule

@@ tb/tb_route_table_cam_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_route_table_cam_top: self-checking bench for the route table CAM
// Sends insert, find, delete and spare-kind requests on the s_ channel and
// checks every m_ result against a shadow copy of the table kept in a small
// scoreboard class. The sender works in bursts with gaps, the receiver stalls
// on a pattern of its own and once holds off long enough to back up intake.
// ----------------------------------------------------------------------------
module tb_route_table_cam_top;
    import rtc_pkg::*;

    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int RAND_ITEMS  = 1535;
    localparam int PHASE_LEN   = 60;
    localparam int POOL_SIZE   = 20;
    localparam int HOLD_AFTER  = 400;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN       = 40;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_SHOWN   = 10;

    // kinds with no operation behind them
    localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;    // key_mac[47:0], key_ip[79:48]
    logic [7:0]  s_tuser;    // kind[2:0], zero above
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;    // slot[3:0], found_mac[51:4], found_ip[83:52], zero above
    logic [7:0]  m_tuser;    // status[1:0], zero above

    int unsigned items_sent;
    bit          hold_done;
    logic [MAC_W-1:0] pool_mac [POOL_SIZE];
    logic [IP_W-1:0]  pool_ip  [POOL_SIZE];

    route_table_cam_top #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // ------------------------------------------------------------------------
    // shadow table and queue of expected replies
    // ------------------------------------------------------------------------
    class route_table_shadow;
        bit               used  [TABLE_DEPTH];
        logic [MAC_W-1:0] macs  [TABLE_DEPTH];
        logic [IP_W-1:0]  ips   [TABLE_DEPTH];
        result_t          pending_replies [$];
        int unsigned      fault_count;

        function new();
            foreach (used[i]) used[i] = 1'b0;
            fault_count = 0;
        endfunction

        function void flag(string what);
            fault_count++;
            if (fault_count <= MAX_SHOWN) $display("%s", what);
        endfunction

        function int lowest_match(bit by_mac, logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip);
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (used[i] && (by_mac ? (macs[i] == mac) : (ips[i] == ip))) return i;
            end
            return -1;
        endfunction

        function result_t hit_reply(int idx);
            result_t r;
            r        = '0;
            r.status = ST_OK;
            r.slot   = idx[SLOT_W-1:0];
            r.mac    = macs[idx];
            r.ip     = ips[idx];
            return r;
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [MAC_W-1:0] mac,
                                   logic [IP_W-1:0] ip);
            result_t r;
            int      idx;
            r        = '0;
            r.status = ST_MISS;
            idx      = -1;
            case (kind)
                KIND_INSERT: begin
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--) if (!used[i]) idx = i;
                    if (idx < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        used[idx] = 1'b1;
                        macs[idx] = mac;
                        ips[idx]  = ip;
                        r = hit_reply(idx);
                    end
                end
                KIND_FIND_IP, KIND_FIND_MAC: begin
                    idx = lowest_match(kind == KIND_FIND_MAC, mac, ip);
                    if (idx >= 0) r = hit_reply(idx);
                end
                KIND_DEL_IP, KIND_DEL_MAC: begin
                    idx = lowest_match(kind == KIND_DEL_MAC, mac, ip);
                    if (idx >= 0) begin
                        r = hit_reply(idx);
                        used[idx] = 1'b0;
                    end
                end
                default: ;
            endcase
            pending_replies.push_back(r);
        endfunction

        function void check_result(logic [87:0] tdata, logic [7:0] tuser);
            result_t want;
            if (pending_replies.size() == 0) begin
                flag($sformatf("unexpected result: status %0d slot %0d mac %h ip %h",
                               tuser[1:0], tdata[3:0], tdata[51:4], tdata[83:52]));
                return;
            end
            want = pending_replies.pop_front();
            if (tuser[1:0] !== want.status || tdata[3:0] !== want.slot ||
                tdata[51:4] !== want.mac || tdata[83:52] !== want.ip) begin
                flag($sformatf("mismatch: want status %0d slot %0d mac %h ip %h",
                               want.status, want.slot, want.mac, want.ip));
                if (fault_count <= MAX_SHOWN)
                    $display("          got  status %0d slot %0d mac %h ip %h",
                             tuser[1:0], tdata[3:0], tdata[51:4], tdata[83:52]);
            end
        endfunction
    endclass

    route_table_shadow shadow;

    // ------------------------------------------------------------------------
    // clock, watchdog, result monitor
    // ------------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("tb_route_table_cam_top NOT OK");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) shadow.check_result(m_tdata, m_tuser);
    end

    // ------------------------------------------------------------------------
    // receiver: random stall pattern, one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int run_len;
        int stall_pct;
        m_tready <= 1'b0;
        hold_done = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!hold_done && items_sent >= HOLD_AFTER) begin
                // hold off so the block backs up and drops s_tready
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            run_len = $urandom_range(4, 40);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 50;
                default: stall_pct = 85;
            endcase
            repeat (run_len) begin
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [MAC_W-1:0] mac,
                                input logic [IP_W-1:0] ip);
        s_tvalid <= 1'b1;
        s_tuser  <= {{(8 - KIND_W){1'b0}}, kind};
        s_tdata  <= {ip, mac};
        do @(posedge aclk); while (!s_tready);
        shadow.note_request(kind, mac, ip);
        items_sent++;
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    // mostly pool keys so finds and deletes hit; sometimes mixed or fresh
    task automatic pick_pair(output logic [MAC_W-1:0] mac, output logic [IP_W-1:0] ip);
        int r;
        int i;
        int j;
        r = $urandom_range(0, 99);
        i = $urandom_range(0, POOL_SIZE - 1);
        j = $urandom_range(0, POOL_SIZE - 1);
        if (r < 70) begin
            mac = pool_mac[i];
            ip  = pool_ip[i];
        end else if (r < 85) begin
            mac = pool_mac[i];
            ip  = pool_ip[j];
        end else if (r < 95) begin
            mac = rand_mac();
            ip  = $urandom;
        end else begin
            mac = ($urandom_range(0, 1) != 0) ? '1 : '0;
            ip  = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
    endtask

    function automatic logic [KIND_W-1:0] pick_kind(int ins_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
        if (r < 3 + ins_pct) return KIND_INSERT;
        case ($urandom_range(0, 3))
            0:       return KIND_FIND_IP;
            1:       return KIND_FIND_MAC;
            2:       return KIND_DEL_IP;
            default: return KIND_DEL_MAC;
        endcase
    endfunction

    initial begin
        int               burst_left;
        int               gap;
        int               ins_pct;
        logic [KIND_W-1:0] kind;
        logic [MAC_W-1:0]  mac;
        logic [IP_W-1:0]   ip;

        shadow     = new();
        items_sent = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_mac[i] = rand_mac();
            pool_ip[i]  = $urandom;
        end
        // shared MAC with distinct IPs, shared IP with distinct MACs
        pool_mac[1] = pool_mac[0];
        pool_ip[3]  = pool_ip[2];

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: misses on an empty table, spare kinds, extremes, duplicates
        send_request(KIND_FIND_IP, '0, '0);
        send_request(KIND_FIND_MAC, '1, '1);
        send_request(KIND_DEL_IP, '1, '1);
        send_request(KIND_DEL_MAC, '0, '0);
        send_request(KIND_SPARE_FIRST, '1, '1);
        send_request(KIND_SPARE_FIRST + 3'd1, '0, '0);
        send_request(KIND_SPARE_LAST, '1, '0);
        send_request(KIND_INSERT, '0, '0);
        send_request(KIND_INSERT, '1, '1);
        send_request(KIND_INSERT, '1, '1);
        send_request(KIND_FIND_IP, '0, '1);
        send_request(KIND_FIND_MAC, '0, '1);
        send_request(KIND_DEL_MAC, '1, '0);
        send_request(KIND_FIND_IP, '0, '1);
        send_request(KIND_DEL_IP, '1, '0);
        send_request(KIND_INSERT, pool_mac[0], pool_ip[0]);

        // random: alternate fill and drain phases so the table fills up
        burst_left = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            ins_pct = (((n / PHASE_LEN) % 2) == 0) ? 65 : 12;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 30);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
            kind = pick_kind(ins_pct);
            pick_pair(mac, ip);
            send_request(kind, mac, ip);
        end
        s_tvalid <= 1'b0;

        while (shadow.pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        if (shadow.fault_count == 0 && shadow.pending_replies.size() == 0) begin
            $display("tb_route_table_cam_top OK");
        end else begin
            $display("tb_route_table_cam_top NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/rtc_pkg.sv
sv/rtc_store.sv
sv/rtc_seq.sv
sv/route_table_cam_top.sv
tb/tb_route_table_cam_top.sv
